[design/edt_pkg.sv]
// Shared types and constants for the edit distance with transposition block.
`timescale 1ns / 1ps

package edt_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int SYM_W       = 8;
    localparam int DIST_W      = 7;
    localparam int ACT_W       = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND_A = 2'd0,
        ACT_APPEND_B = 2'd1,
        ACT_COMPUTE  = 2'd2,
        ACT_NOP      = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_ROW_WAIT,
        S_READ,
        S_CALC,
        S_DONE
    } t_state;

    // Symbols and the crossed-match enable seen by the cell unit.
    typedef struct packed {
        logic [SYM_W-1:0] a;
        logic [SYM_W-1:0] b;
        logic [SYM_W-1:0] a_prev;
        logic [SYM_W-1:0] b_prev;
        logic             trans_en;
    } t_cell_sym;

endpackage

[design/edt_str_mem.sv]
// Symbol store for one string: one write port, one registered read port.
`timescale 1ns / 1ps

module edt_str_mem #(
    parameter int DEPTH = edt_pkg::MAX_LEN_DEF,
    parameter int AW    = $clog2(edt_pkg::MAX_LEN_DEF)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [edt_pkg::SYM_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [edt_pkg::SYM_W-1:0] o_rdata
);

    logic [edt_pkg::SYM_W-1:0] r_mem [DEPTH];
    logic [edt_pkg::SYM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/edt_row_mem.sv]
// Three rolling row banks of the distance matrix with rotating roles.
`timescale 1ns / 1ps

module edt_row_mem #(
    parameter int DEPTH = edt_pkg::MAX_LEN_DEF,
    parameter int AW    = $clog2(edt_pkg::MAX_LEN_DEF),
    parameter int VW    = $clog2(edt_pkg::MAX_LEN_DEF + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rotate,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [VW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_one,
    input  logic [AW-1:0] i_raddr_two,
    output logic [VW-1:0] o_rdata_one,
    output logic [VW-1:0] o_rdata_two
);

    logic [1:0]    r_cur;
    logic [1:0]    n_cur;
    logic [1:0]    one_bank;
    logic [1:0]    two_bank;
    logic [VW-1:0] r_rd [3];

    // Current row bank advances by one each row; the others follow behind it.
    always_comb begin
        unique case (r_cur)
            2'd0:    begin one_bank = 2'd2; two_bank = 2'd1; n_cur = 2'd1; end
            2'd1:    begin one_bank = 2'd0; two_bank = 2'd2; n_cur = 2'd2; end
            default: begin one_bank = 2'd1; two_bank = 2'd0; n_cur = 2'd0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= 2'd0;
        end else if (i_rotate) begin
            r_cur <= n_cur;
        end
    end

    for (genvar b = 0; b < 3; b++) begin : g_bank
        localparam logic [1:0] BANK = 2'(b);
        logic [VW-1:0] r_mem [DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_we && r_cur == BANK) begin
                r_mem[i_waddr] <= i_wdata;
            end
            r_rd[b] <= r_mem[(one_bank == BANK) ? i_raddr_one : i_raddr_two];
        end
    end

    assign o_rdata_one = r_rd[one_bank];
    assign o_rdata_two = r_rd[two_bank];

endmodule

[design/edt_cell.sv]
// Cell unit: minimum over insertion, deletion, substitution and transposition.
`timescale 1ns / 1ps

module edt_cell #(
    parameter int VW = $clog2(edt_pkg::MAX_LEN_DEF + 1)
) (
    input  logic [VW-1:0]      i_up,
    input  logic [VW-1:0]      i_left,
    input  logic [VW-1:0]      i_diag,
    input  logic [VW-1:0]      i_two,
    input  edt_pkg::t_cell_sym i_sym,
    output logic [VW-1:0]      o_cell
);

    logic [VW:0] up_c;
    logic [VW:0] left_c;
    logic [VW:0] sub_c;
    logic [VW:0] two_c;
    logic [VW:0] m0;
    logic [VW:0] m1;
    logic [VW:0] m2;
    logic        crossed;

    always_comb begin
        up_c    = {1'b0, i_up} + (VW+1)'(1);
        left_c  = {1'b0, i_left} + (VW+1)'(1);
        sub_c   = {1'b0, i_diag} + (VW+1)'(i_sym.a != i_sym.b);
        two_c   = {1'b0, i_two} + (VW+1)'(1);
        crossed = i_sym.trans_en && (i_sym.a == i_sym.b_prev) && (i_sym.a_prev == i_sym.b);
        m0      = (up_c < left_c) ? up_c : left_c;
        m1      = (sub_c < m0) ? sub_c : m0;
        m2      = (crossed && two_c < m1) ? two_c : m1;
        o_cell  = m2[VW-1:0];
    end

endmodule

[design/edit_distance_with_transposition.sv]
// Top level: string loading, cell sequencer and result register.
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+-------------------------------
//  command  | i_action, i_symbol                  | start high while busy low
//  result   | o_distance, o_overflow              | o_valid high for one cycle
//
// Appends leave busy low. A compute transaction keeps busy high while the
// single cell unit works through the matrix: per row it first fetches the row
// symbol, then handles each cell in turn (read, then compute and write back),
// and after the last row it shows the result; with either string empty busy
// is high only in the result state.
// Reset is synchronous and clears lengths, overflow flag and sequencer.
// The receiver cannot stall; each result shows for exactly one cycle.
`timescale 1ns / 1ps

module edit_distance_with_transposition #(
    parameter int MAX_LEN = edt_pkg::MAX_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [edt_pkg::ACT_W-1:0]  i_action,
    input  logic [edt_pkg::SYM_W-1:0]  i_symbol,
    output logic                       o_valid,
    output logic [edt_pkg::DIST_W-1:0] o_distance,
    output logic                       o_overflow
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int DW    = (LEN_W > edt_pkg::DIST_W) ? LEN_W : edt_pkg::DIST_W;
    localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_LEN);

    edt_pkg::t_state  r_state;
    edt_pkg::t_state  n_state;
    edt_pkg::t_action act;

    logic [LEN_W-1:0] r_len1, r_len2, r_i, r_j;
    logic             r_ovf;
    logic [LEN_W-1:0] r_dist, r_left, r_diag;
    logic [edt_pkg::SYM_W-1:0] r_a, r_a_prev, r_b_prev;

    logic accept, do_compute, empty, last_col, last_row;
    logic ld_a, ld_b, rd_row, in_calc;

    logic [edt_pkg::SYM_W-1:0] s1_rdata, s2_rdata;
    logic [LEN_W-1:0]          one_rdata, two_rdata;
    logic [LEN_W-1:0]          up_v, left_v, diag_v, two_v, cell_v;
    edt_pkg::t_cell_sym        sym;
    logic [DW-1:0]             dist_wide;

    logic [LEN_W-1:0] i_m1;
    logic [LEN_W-1:0] j_m1;
    logic [LEN_W-1:0] j_m3;

    assign act        = edt_pkg::t_action'(i_action);
    assign accept     = start && !busy;
    assign do_compute = accept && act == edt_pkg::ACT_COMPUTE;
    assign empty      = (r_len1 == '0) || (r_len2 == '0);
    assign last_col   = (r_j == r_len2);
    assign last_row   = (r_i == r_len1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            edt_pkg::S_IDLE: begin
                if (do_compute) begin
                    n_state = empty ? edt_pkg::S_DONE : edt_pkg::S_ROW;
                end
            end
            edt_pkg::S_ROW:      n_state = edt_pkg::S_ROW_WAIT;
            edt_pkg::S_ROW_WAIT: n_state = edt_pkg::S_READ;
            edt_pkg::S_READ:     n_state = edt_pkg::S_CALC;
            edt_pkg::S_CALC: begin
                priority if (!last_col) begin
                    n_state = edt_pkg::S_READ;
                end else if (!last_row) begin
                    n_state = edt_pkg::S_ROW;
                end else begin
                    n_state = edt_pkg::S_DONE;
                end
            end
            edt_pkg::S_DONE:     n_state = edt_pkg::S_IDLE;
            default:             n_state = edt_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        busy    = 1'b1;
        o_valid = 1'b0;
        rd_row  = 1'b0;
        in_calc = 1'b0;
        unique case (r_state)
            edt_pkg::S_IDLE:     busy    = 1'b0;
            edt_pkg::S_ROW_WAIT: rd_row  = 1'b1;
            edt_pkg::S_CALC:     in_calc = 1'b1;
            edt_pkg::S_DONE:     o_valid = 1'b1;
            default:             busy    = 1'b1;
        endcase
    end

    assign ld_a = accept && act == edt_pkg::ACT_APPEND_A;
    assign ld_b = accept && act == edt_pkg::ACT_APPEND_B;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= edt_pkg::S_IDLE;
            r_len1  <= '0;
            r_len2  <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (ld_a) begin
                if (r_len1 < MAX_L) r_len1 <= r_len1 + LEN_W'(1);
                else                r_ovf  <= 1'b1;
            end
            if (ld_b) begin
                if (r_len2 < MAX_L) r_len2 <= r_len2 + LEN_W'(1);
                else                r_ovf  <= 1'b1;
            end
            if (do_compute) begin
                r_i <= LEN_W'(1);
                r_j <= LEN_W'(1);
            end
            if (in_calc) begin
                if (!last_col) begin
                    r_j <= r_j + LEN_W'(1);
                end else begin
                    r_j <= LEN_W'(1);
                    r_i <= r_i + LEN_W'(1);
                end
            end
            // Clear both strings once the result has gone out.
            if (o_valid) begin
                r_len1 <= '0;
                r_len2 <= '0;
                r_ovf  <= 1'b0;
            end
        end
    end

    // Column 0, row 0 and the row two back at row 2 come from the indexes.
    always_comb begin
        up_v   = (r_i == LEN_W'(1)) ? r_j : one_rdata;
        left_v = (r_j == LEN_W'(1)) ? r_i : r_left;
        diag_v = (r_j == LEN_W'(1)) ? (r_i - LEN_W'(1)) : r_diag;
        priority if (r_j == LEN_W'(2)) begin
            two_v = r_i - LEN_W'(2);
        end else if (r_i == LEN_W'(2)) begin
            two_v = r_j - LEN_W'(2);
        end else begin
            two_v = two_rdata;
        end
        sym.a        = r_a;
        sym.b        = s2_rdata;
        sym.a_prev   = r_a_prev;
        sym.b_prev   = r_b_prev;
        sym.trans_en = (r_i >= LEN_W'(2)) && (r_j >= LEN_W'(2));
    end

    always_ff @(posedge i_clk) begin
        if (rd_row) begin
            r_a_prev <= r_a;
            r_a      <= s1_rdata;
        end
        if (in_calc) begin
            r_left   <= cell_v;
            r_diag   <= up_v;
            r_b_prev <= s2_rdata;
            if (last_col && last_row) r_dist <= cell_v;
        end
        // One string is empty: the distance is the other one's length.
        if (do_compute && empty) begin
            r_dist <= r_len1 | r_len2;
        end
    end

    assign i_m1 = r_i - LEN_W'(1);
    assign j_m1 = r_j - LEN_W'(1);
    assign j_m3 = r_j - LEN_W'(3);

    edt_str_mem #(.DEPTH(MAX_LEN), .AW(IDX_W)) u_str_a (
        .i_clk   (i_clk),
        .i_we    (ld_a && r_len1 < MAX_L),
        .i_waddr (r_len1[IDX_W-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (i_m1[IDX_W-1:0]),
        .o_rdata (s1_rdata)
    );

    edt_str_mem #(.DEPTH(MAX_LEN), .AW(IDX_W)) u_str_b (
        .i_clk   (i_clk),
        .i_we    (ld_b && r_len2 < MAX_L),
        .i_waddr (r_len2[IDX_W-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (j_m1[IDX_W-1:0]),
        .o_rdata (s2_rdata)
    );

    edt_row_mem #(.DEPTH(MAX_LEN), .AW(IDX_W), .VW(LEN_W)) u_rows (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rotate    (in_calc && last_col),
        .i_we        (in_calc),
        .i_waddr     (j_m1[IDX_W-1:0]),
        .i_wdata     (cell_v),
        .i_raddr_one (j_m1[IDX_W-1:0]),
        .i_raddr_two (j_m3[IDX_W-1:0]),
        .o_rdata_one (one_rdata),
        .o_rdata_two (two_rdata)
    );

    edt_cell #(.VW(LEN_W)) u_cell (
        .i_up   (up_v),
        .i_left (left_v),
        .i_diag (diag_v),
        .i_two  (two_v),
        .i_sym  (sym),
        .o_cell (cell_v)
    );

    assign dist_wide  = DW'(r_dist);
    assign o_distance = dist_wide[edt_pkg::DIST_W-1:0];
    assign o_overflow = r_ovf;

endmodule

[design/edt_chk.sv]
// Port-level checker for the edit distance block, bound to the top level.
`timescale 1ns / 1ps

module edt_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [edt_pkg::ACT_W-1:0] i_action,
    input logic                      o_valid
);

    logic is_compute;
    assign is_compute = edt_pkg::t_action'(i_action) == edt_pkg::ACT_COMPUTE;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while block reports idle");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && is_compute) |=> busy)
        else $error("compute transaction did not raise busy");

    a_load_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !is_compute) |=> (!busy && !o_valid))
        else $error("append transaction stalled or produced a result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("block not ready after delivering a result");

endmodule

bind edit_distance_with_transposition edt_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_action (i_action),
    .o_valid  (o_valid)
);

[test/tb_edit_distance_with_transposition.sv]
// Testbench for the edit distance with transposition block: queued driver, predictor, monitor.
`timescale 1ns / 1ps

module tb_edit_distance_with_transposition;

    localparam int MAX_LEN     = edt_pkg::MAX_LEN_DEF;
    localparam int RANDOM_CMDS = 1500;
    localparam int DRAIN_CYCLES = 100;
    localparam int SYM_W       = edt_pkg::SYM_W;
    localparam int DIST_W      = edt_pkg::DIST_W;
    localparam int ACT_W       = edt_pkg::ACT_W;

    typedef struct {
        edt_pkg::t_action action;
        logic [SYM_W-1:0] symbol;
        int unsigned      idle_pct;
    } t_command;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_distance_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [ACT_W-1:0]      i_action = edt_pkg::ACT_NOP;
    logic [SYM_W-1:0]      i_symbol = '0;
    logic                  o_valid;
    logic [DIST_W-1:0]     o_distance;
    logic                  o_overflow;

    t_command              cmd_queue[$];
    t_distance_result      distance_queue[$];

    // Predictor state
    logic [SYM_W-1:0]      ld_first[0:MAX_LEN-1];
    logic [SYM_W-1:0]      ld_second[0:MAX_LEN-1];
    int unsigned           len_first = 0;
    int unsigned           len_second = 0;
    logic                  drop_seen = 1'b0;

    // Stimulus planning
    int unsigned           plan_first = 0;
    int unsigned           plan_second = 0;
    longint unsigned       cycle_budget = 0;
    longint unsigned       cycle_limit = 64'd10_000_000;
    longint unsigned       cycle_count = 0;
    int unsigned           cur_idle = 0;
    int unsigned           cmds_queued = 0;

    logic                  cmd_taken = 1'b0;
    int unsigned           cmds_accepted = 0;
    int unsigned           results_checked = 0;
    int unsigned           overflow_results = 0;
    int unsigned           err_count = 0;

    edit_distance_with_transposition #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_action  (i_action),
        .i_symbol  (i_symbol),
        .o_valid   (o_valid),
        .o_distance(o_distance),
        .o_overflow(o_overflow)
    );

    always #10 i_clk = ~i_clk;

    // Optimal string alignment distance over the loaded strings, three rolling rows.
    function automatic logic [DIST_W-1:0] osa_distance();
        int unsigned two_back[0:MAX_LEN];
        int unsigned one_back[0:MAX_LEN];
        int unsigned cur_row[0:MAX_LEN];
        int unsigned best;
        logic [SYM_W-1:0] a;
        logic [SYM_W-1:0] b;
        for (int j = 0; j <= MAX_LEN; j++) begin
            two_back[j] = 0;
            cur_row[j]  = 0;
            one_back[j] = j;
        end
        for (int i = 1; i <= len_first; i++) begin
            a = ld_first[i-1];
            cur_row[0] = i;
            for (int j = 1; j <= len_second; j++) begin
                b = ld_second[j-1];
                best = one_back[j] + 1;
                if (cur_row[j-1] + 1 < best)
                    best = cur_row[j-1] + 1;
                if (one_back[j-1] + ((a != b) ? 1 : 0) < best)
                    best = one_back[j-1] + ((a != b) ? 1 : 0);
                // crossed pair: adjacent swap
                if (i >= 2 && j >= 2 && a == ld_second[j-2] && ld_first[i-2] == b &&
                    two_back[j-2] + 1 < best)
                    best = two_back[j-2] + 1;
                cur_row[j] = best;
            end
            two_back = one_back;
            one_back = cur_row;
        end
        return one_back[len_second][DIST_W-1:0];
    endfunction

    task automatic apply_command(input edt_pkg::t_action act, input logic [SYM_W-1:0] sym);
        t_distance_result res;
        case (act)
            edt_pkg::ACT_APPEND_A: begin
                if (len_first < MAX_LEN) begin
                    ld_first[len_first] = sym;
                    len_first++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            edt_pkg::ACT_APPEND_B: begin
                if (len_second < MAX_LEN) begin
                    ld_second[len_second] = sym;
                    len_second++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            edt_pkg::ACT_COMPUTE: begin
                res.distance = osa_distance();
                res.overflow = drop_seen;
                distance_queue.push_back(res);
                len_first  = 0;
                len_second = 0;
                drop_seen  = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic push_cmd(input edt_pkg::t_action act, input logic [SYM_W-1:0] sym);
        t_command c;
        c.action   = act;
        c.symbol   = sym;
        c.idle_pct = cur_idle;
        cmd_queue.push_back(c);
        cycle_budget += 8;
        cmds_queued++;
        case (act)
            edt_pkg::ACT_APPEND_A: if (plan_first < MAX_LEN) plan_first++;
            edt_pkg::ACT_APPEND_B: if (plan_second < MAX_LEN) plan_second++;
            edt_pkg::ACT_COMPUTE: begin
                cycle_budget += 2 + plan_first * (2 * plan_second + 2);
                plan_first  = 0;
                plan_second = 0;
            end
            default: ;
        endcase
    endtask

    // Load two strings interleaved, then compute. alpha 0 means the full byte range.
    task automatic gen_pair(input int unsigned la, input int unsigned lb,
                            input int unsigned alpha, input bit derive);
        logic [SYM_W-1:0] sa[$];
        logic [SYM_W-1:0] sb[$];
        logic [SYM_W-1:0] tmp;
        logic [SYM_W-1:0] base;
        int unsigned ia;
        int unsigned ib;
        base = SYM_W'($urandom_range(0, 255 - alpha));
        for (int k = 0; k < la; k++)
            sa.push_back(alpha == 0 ? SYM_W'($urandom_range(0, 255))
                                    : base + SYM_W'($urandom_range(0, alpha - 1)));
        if (derive) begin
            sb = sa;
            for (int k = 0; k + 1 < sb.size(); k++) begin
                if ($urandom_range(0, 99) < 15) begin
                    tmp     = sb[k];
                    sb[k]   = sb[k+1];
                    sb[k+1] = tmp;
                end else if ($urandom_range(0, 99) < 10) begin
                    sb[k] = SYM_W'($urandom_range(0, 255));
                end
            end
            if (sb.size() > 0 && $urandom_range(0, 3) == 0)
                sb.delete($urandom_range(0, sb.size() - 1));
        end else begin
            for (int k = 0; k < lb; k++)
                sb.push_back(alpha == 0 ? SYM_W'($urandom_range(0, 255))
                                        : base + SYM_W'($urandom_range(0, alpha - 1)));
        end
        ia = 0;
        ib = 0;
        while (ia < sa.size() || ib < sb.size()) begin
            if (ib >= sb.size() || (ia < sa.size() && $urandom_range(0, 1) == 0)) begin
                push_cmd(edt_pkg::ACT_APPEND_A, sa[ia]);
                ia++;
            end else begin
                push_cmd(edt_pkg::ACT_APPEND_B, sb[ib]);
                ib++;
            end
            if ($urandom_range(0, 99) < 3)
                push_cmd(edt_pkg::ACT_NOP, SYM_W'($urandom_range(0, 255)));
        end
        push_cmd(edt_pkg::ACT_COMPUTE, SYM_W'($urandom_range(0, 255)));
    endtask

    task automatic gen_random_sequence();
        int unsigned kind;
        int unsigned la;
        int unsigned lb;
        int unsigned alpha;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            la = ($urandom_range(0, 99) < 3) ? $urandom_range(9, MAX_LEN + 6)
                                             : $urandom_range(0, 8);
            lb = ($urandom_range(0, 99) < 3) ? $urandom_range(9, MAX_LEN + 6)
                                             : $urandom_range(0, 8);
            alpha = ($urandom_range(0, 99) < 20) ? 0 : $urandom_range(1, 4);
            gen_pair(la, lb, alpha, 1'($urandom_range(0, 1)));
        end else if (kind < 90) begin
            // noise: any action, any symbol
            repeat ($urandom_range(1, 6))
                push_cmd(edt_pkg::t_action'($urandom_range(0, 3)),
                         SYM_W'($urandom_range(0, 255)));
        end else begin
            // broken: loads with no compute, carried into the next sequence
            repeat ($urandom_range(1, 5))
                push_cmd(edt_pkg::t_action'($urandom_range(0, 1)),
                         SYM_W'($urandom_range(0, 255)));
            push_cmd(edt_pkg::ACT_NOP, SYM_W'($urandom_range(0, 255)));
        end
    endtask

    // Driver: present a transaction at the falling edge, hold until accepted.
    always @(negedge i_clk) begin : drive
        t_command c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || cmd_taken) begin
            if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= cmd_queue[0].idle_pct) begin
                c = cmd_queue.pop_front();
                start    <= 1'b1;
                i_action <= c.action;
                i_symbol <= c.symbol;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check results, then predict from the transaction taken at this edge.
    always @(posedge i_clk) begin : monitor
        t_distance_result exp_res;
        if (i_rst_n && o_valid === 1'b1) begin
            if (distance_queue.size() == 0) begin
                $display("%0t: unexpected result: expected none, got distance %0d overflow %0b",
                         $time, o_distance, o_overflow);
                err_count++;
            end else begin
                exp_res = distance_queue.pop_front();
                results_checked++;
                if (exp_res.overflow)
                    overflow_results++;
                if (o_distance !== exp_res.distance) begin
                    $display("%0t: distance mismatch: expected %0d, got %0d",
                             $time, exp_res.distance, o_distance);
                    err_count++;
                end
                if (o_overflow !== exp_res.overflow) begin
                    $display("%0t: overflow mismatch: expected %0b, got %0b",
                             $time, exp_res.overflow, o_overflow);
                    err_count++;
                end
            end
        end
        cmd_taken = i_rst_n && start && (busy === 1'b0);
        if (cmd_taken) begin
            cmds_accepted++;
            apply_command(edt_pkg::t_action'(i_action), i_symbol);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > cycle_limit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, distance_queue.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned phase_end;
        int unsigned idle_plan[4];

        // Directed: empty strings, one side empty, extreme symbols, swaps, unused action
        cur_idle = 0;
        push_cmd(edt_pkg::ACT_COMPUTE, 8'h00);
        push_cmd(edt_pkg::ACT_APPEND_A, 8'h00);
        push_cmd(edt_pkg::ACT_COMPUTE, 8'hFF);
        push_cmd(edt_pkg::ACT_APPEND_B, 8'hFF);
        push_cmd(edt_pkg::ACT_APPEND_B, 8'h00);
        push_cmd(edt_pkg::ACT_APPEND_B, 8'h7F);
        push_cmd(edt_pkg::ACT_COMPUTE, 8'h00);
        push_cmd(edt_pkg::ACT_APPEND_A, 8'h61);
        push_cmd(edt_pkg::ACT_APPEND_B, 8'h62);
        push_cmd(edt_pkg::ACT_APPEND_A, 8'h62);
        push_cmd(edt_pkg::ACT_APPEND_B, 8'h61);
        push_cmd(edt_pkg::ACT_COMPUTE, 8'h55);
        push_cmd(edt_pkg::ACT_APPEND_A, 8'hFF);
        push_cmd(edt_pkg::ACT_APPEND_A, 8'h00);
        push_cmd(edt_pkg::ACT_APPEND_A, 8'h12);
        push_cmd(edt_pkg::ACT_APPEND_B, 8'hFF);
        push_cmd(edt_pkg::ACT_APPEND_B, 8'h12);
        push_cmd(edt_pkg::ACT_APPEND_B, 8'h00);
        push_cmd(edt_pkg::ACT_COMPUTE, 8'hAA);
        push_cmd(edt_pkg::ACT_NOP, 8'hAA);
        push_cmd(edt_pkg::ACT_APPEND_A, 8'h80);
        push_cmd(edt_pkg::ACT_NOP, 8'h55);
        push_cmd(edt_pkg::ACT_APPEND_B, 8'h80);
        push_cmd(edt_pkg::ACT_COMPUTE, 8'h00);

        // Full-size strings: overflow on each side and the widest distance
        gen_pair(MAX_LEN + 6, 0, 0, 1'b0);
        gen_pair(0, MAX_LEN + 2, 0, 1'b0);
        gen_pair(MAX_LEN, MAX_LEN, 2, 1'b0);
        gen_pair(MAX_LEN + 2, 0, 0, 1'b1);

        // Phases: no gaps, sender gaps 56 in 100, no gaps, sender gaps 35 in 100
        idle_plan = '{0, 56, 0, 35};
        for (int ph = 0; ph < 4; ph++) begin
            cur_idle  = idle_plan[ph];
            phase_end = cmds_queued + RANDOM_CMDS / 4;
            while (cmds_queued < phase_end)
                gen_random_sequence();
        end
        push_cmd(edt_pkg::ACT_COMPUTE, SYM_W'($urandom_range(0, 255)));
        cycle_limit = 4 * cycle_budget + 20_000;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || distance_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions in %0d cycles,", cmds_accepted, cycle_count);
        $display("%0d distances checked, %0d of them flagged overflow",
                 results_checked, overflow_results);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
design/edt_pkg.sv
design/edt_str_mem.sv
design/edt_row_mem.sv
design/edt_cell.sv
design/edit_distance_with_transposition.sv
design/edt_chk.sv
test/tb_edit_distance_with_transposition.sv
